@@ rtl/bezier_curve_point_eval_macros.svh @@
// Assertion macros shared by the Bezier evaluator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BEZIER_CURVE_POINT_EVAL_MACROS_SVH
`define BEZIER_CURVE_POINT_EVAL_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BCPE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bezier evaluator assertion failed");

// Next-cycle implication, checked out of reset.
`define BCPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bezier evaluator assertion failed");

`endif

@@ rtl/bcpe_pkg.sv @@
// Package for the Bezier curve point evaluator: sizes, constants and the
// control struct that the top level hands to each point cell. No dependencies.
`timescale 1ns / 1ps
package bcpe_pkg;

  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 32;
  localparam int T_W        = 17;
  localparam int PROD_W     = COORD_W + 1 + T_W + 1;

  localparam logic [T_W-1:0] T_ONE = T_W'(65536);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic           mul_en;
    logic           add_en;
    logic [T_W-1:0] t;
  } bcpe_ctrl_t;

endpackage

@@ rtl/bcpe_cell.sv @@
// One cell of the point chain: holds one control point and blends it toward
// its right neighbor in two steps (multiply, then add). Uses bcpe_pkg.
`timescale 1ns / 1ps
module bcpe_cell (
  input  logic                clk,
  input  logic                load_en,
  input  bcpe_pkg::coord_t    load_x,
  input  bcpe_pkg::coord_t    load_y,
  input  bcpe_pkg::coord_t    nbr_x,
  input  bcpe_pkg::coord_t    nbr_y,
  input  bcpe_pkg::bcpe_ctrl_t ctrl,
  output bcpe_pkg::coord_t    pt_x,
  output bcpe_pkg::coord_t    pt_y
);
  import bcpe_pkg::*;

  coord_t                    x_r;
  coord_t                    y_r;
  coord_t                    prodx_r;
  coord_t                    prody_r;
  logic signed [COORD_W:0]   diff_x;
  logic signed [COORD_W:0]   diff_y;
  logic signed [T_W:0]       t_s;
  logic signed [PROD_W-1:0]  mul_x;
  logic signed [PROD_W-1:0]  mul_y;

  // The blend a*(1-t) + b*t equals a + floor((b-a)*t / 2^16); the sum wraps
  // correctly in 32 bits because the result lies between a and b.
  always_comb begin
    diff_x = {nbr_x[COORD_W-1], nbr_x} - {x_r[COORD_W-1], x_r};
    diff_y = {nbr_y[COORD_W-1], nbr_y} - {y_r[COORD_W-1], y_r};
    t_s    = $signed({1'b0, ctrl.t});
    mul_x  = diff_x * t_s;
    mul_y  = diff_y * t_s;
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      x_r <= load_x;
      y_r <= load_y;
    end else if (ctrl.add_en) begin
      x_r <= x_r + prodx_r;
      y_r <= y_r + prody_r;
    end
    if (ctrl.mul_en) begin
      prodx_r <= mul_x[COORD_W+15:16];
      prody_r <= mul_y[COORD_W+15:16];
    end
  end

  assign pt_x = x_r;
  assign pt_y = y_r;

endmodule

@@ rtl/bezier_curve_point_eval.sv @@
// Each round of de Casteljau takes two steps (multiply, add) in all cells
// of the chain at once; an n-point curve takes n-1 rounds, and the point
// is then moved to the output register once that register is free.
// Throughput: one point per cycle while loading; the input stalls for the
// reduction rounds and until the point has moved to the output register.
// Reset clears the point count, drop flag, sequencer and output valid only.
`timescale 1ns / 1ps
`include "bezier_curve_point_eval_macros.svh"
module bezier_curve_point_eval (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [31:0]        in_point_x,
  input  logic signed [31:0]        in_point_y,
  input  logic [16:0]               in_param_t,
  input  logic                      in_last_point,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [31:0]        out_curve_x,
  output logic signed [31:0]        out_curve_y,
  output logic                      out_too_many_points
);
  import bcpe_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             dropped_r, dropped_nxt;
  logic [IDX_W-1:0] round_r, round_nxt;
  logic             phase_r, phase_nxt;
  logic [T_W-1:0]   t_r, t_nxt;
  logic             flag_r, flag_nxt;
  logic             out_valid_r, out_valid_nxt;
  coord_t           out_x_r, out_y_r;
  logic             out_flag_r;

  logic             in_acc;
  logic             store_ok;
  logic             out_load;
  logic [CNT_W-1:0] n_pts;
  bcpe_ctrl_t       ctrl;

  coord_t           cell_x [MAX_POINTS];
  coord_t           cell_y [MAX_POINTS];
  logic [MAX_POINTS-1:0] load_en;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign store_ok = (cnt_r < CNT_W'(MAX_POINTS));
  assign n_pts    = store_ok ? cnt_r + CNT_W'(1) : cnt_r;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    dropped_nxt   = dropped_r;
    round_nxt     = round_r;
    phase_nxt     = phase_r;
    t_nxt         = t_r;
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctrl.mul_en   = 1'b0;
    ctrl.add_en   = 1'b0;
    ctrl.t        = t_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_last_point) begin
            cnt_nxt     = '0;
            dropped_nxt = 1'b0;
            flag_nxt    = dropped_r || !store_ok;
            t_nxt       = (in_param_t > T_ONE) ? T_ONE : in_param_t;
            round_nxt   = IDX_W'(n_pts - CNT_W'(1));
            phase_nxt   = 1'b0;
            state_nxt   = (n_pts == CNT_W'(1)) ? S_DONE : S_CALC;
          end else begin
            cnt_nxt     = n_pts;
            dropped_nxt = dropped_r || !store_ok;
          end
        end
      end
      S_CALC: begin
        if (!phase_r) begin
          ctrl.mul_en = 1'b1;
          phase_nxt   = 1'b1;
        end else begin
          ctrl.add_en = 1'b1;
          phase_nxt   = 1'b0;
          if (round_r == IDX_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            round_nxt = round_r - IDX_W'(1);
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      round_r     <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      round_r     <= round_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    flag_r <= flag_nxt;
    if (out_load) begin
      out_x_r    <= cell_x[0];
      out_y_r    <= cell_y[0];
      out_flag_r <= flag_r;
    end
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    assign load_en[i] = in_acc && store_ok && (cnt_r[IDX_W-1:0] == IDX_W'(i));
    if (i == MAX_POINTS - 1) begin : g_tail
      bcpe_cell u_cell (
        .clk     (clk),
        .load_en (load_en[i]),
        .load_x  (in_point_x),
        .load_y  (in_point_y),
        .nbr_x   (cell_x[i]),
        .nbr_y   (cell_y[i]),
        .ctrl    (ctrl),
        .pt_x    (cell_x[i]),
        .pt_y    (cell_y[i])
      );
    end else begin : g_body
      bcpe_cell u_cell (
        .clk     (clk),
        .load_en (load_en[i]),
        .load_x  (in_point_x),
        .load_y  (in_point_y),
        .nbr_x   (cell_x[i+1]),
        .nbr_y   (cell_y[i+1]),
        .ctrl    (ctrl),
        .pt_x    (cell_x[i]),
        .pt_y    (cell_y[i])
      );
    end
  end

  assign out_valid           = out_valid_r;
  assign out_curve_x         = out_x_r;
  assign out_curve_y         = out_y_r;
  assign out_too_many_points = out_flag_r;

  `BCPE_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_POINTS))
  `BCPE_ASSERT_SAME(a_drop_full, dropped_r, cnt_r == CNT_W'(MAX_POINTS))
  `BCPE_ASSERT_NEXT(a_last_busy, in_acc && in_last_point, state_r != S_IDLE)
  `BCPE_ASSERT_SAME(a_calc_round, state_r == S_CALC, round_r != '0)
  `BCPE_ASSERT_NEXT(a_load_idle, out_load, out_valid_r && state_r == S_IDLE)

endmodule
